// ===== hw/rtl/psd_pkg.sv =====
`default_nettype none

package psd_pkg;

    // Default coordinate word and fraction widths.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Width of the tolerance register and its write port.
    localparam int TOL_WIDTH = 16;

endpackage

`default_nettype wire

// ===== hw/rtl/psd_div2.sv =====
`default_nettype none

module psd_div2 #(
    parameter int QW   = 33,
    parameter int DENW = 67,
    parameter int TW   = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [DENW+QW-1:0]   num_x,
    input  wire logic [DENW+QW-1:0]   num_y,
    input  wire logic [DENW-1:0]      den,
    input  wire logic [TW-1:0]        tag_in,
    output logic                      out_valid,
    output logic [QW-1:0]             quo_x,
    output logic [QW-1:0]             quo_y,
    output logic [TW-1:0]             tag_out
);

    // Two restoring dividers sharing one divisor, one quotient bit per stage.
    // The quotient is known to fit in QW bits, so the top of the numerator
    // already lies below the divisor and only QW steps are needed.
    logic            valid_reg [QW];
    logic [DENW-1:0] prx_reg   [QW];
    logic [DENW-1:0] pry_reg   [QW];
    logic [QW-1:0]   nqx_reg   [QW];
    logic [QW-1:0]   nqy_reg   [QW];
    logic [DENW-1:0] den_reg   [QW];
    logic [TW-1:0]   tag_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic            valid_in;
        logic [DENW-1:0] prx_in, pry_in, den_in;
        logic [QW-1:0]   nqx_in, nqy_in;
        logic [TW-1:0]   tag_stage_in;
        logic [DENW:0]   tx, ty, dfx, dfy;
        logic            gex, gey;
        logic [DENW-1:0] prx_next, pry_next;
        logic [QW-1:0]   nqx_next, nqy_next;

        if (k == 0) begin : g_first
            assign valid_in     = in_valid;
            assign prx_in       = num_x[DENW+QW-1:QW];
            assign pry_in       = num_y[DENW+QW-1:QW];
            assign nqx_in       = num_x[QW-1:0];
            assign nqy_in       = num_y[QW-1:0];
            assign den_in       = den;
            assign tag_stage_in = tag_in;
        end else begin : g_rest
            assign valid_in     = valid_reg[k-1];
            assign prx_in       = prx_reg[k-1];
            assign pry_in       = pry_reg[k-1];
            assign nqx_in       = nqx_reg[k-1];
            assign nqy_in       = nqy_reg[k-1];
            assign den_in       = den_reg[k-1];
            assign tag_stage_in = tag_reg[k-1];
        end

        always_comb begin
            tx       = {prx_in, nqx_in[QW-1]};
            ty       = {pry_in, nqy_in[QW-1]};
            dfx      = tx - {1'b0, den_in};
            dfy      = ty - {1'b0, den_in};
            gex      = (tx >= {1'b0, den_in});
            gey      = (ty >= {1'b0, den_in});
            prx_next = gex ? dfx[DENW-1:0] : tx[DENW-1:0];
            pry_next = gey ? dfy[DENW-1:0] : ty[DENW-1:0];
            nqx_next = {nqx_in[QW-2:0], gex};
            nqy_next = {nqy_in[QW-2:0], gey};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prx_reg[k] <= prx_next;
                pry_reg[k] <= pry_next;
                nqx_reg[k] <= nqx_next;
                nqy_reg[k] <= nqy_next;
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_stage_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo_x     = nqx_reg[QW-1];
    assign quo_y     = nqy_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/psd_isqrt.sv =====
`default_nettype none

module psd_isqrt #(
    parameter int SW = 67,
    parameter int RW = 34,
    parameter int TW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [SW-1:0] radicand,
    input  wire logic [TW-1:0] tag_in,
    output logic               out_valid,
    output logic [RW-1:0]      root,
    output logic [TW-1:0]      tag_out
);

    // Digit-by-digit square root, one root bit per stage, truncating.
    logic            valid_reg [RW];
    logic [RW:0]     rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [2*RW-1:0] rad_reg   [RW];
    logic [TW-1:0]   tag_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic            valid_in;
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [TW-1:0]   tag_stage_in;
        logic [RW+2:0]   t, trial, diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign valid_in     = in_valid;
            assign rem_in       = '0;
            assign root_in      = '0;
            assign rad_in       = {{(2*RW-SW){1'b0}}, radicand};
            assign tag_stage_in = tag_in;
        end else begin : g_rest
            assign valid_in     = valid_reg[k-1];
            assign rem_in       = rem_reg[k-1];
            assign root_in      = root_reg[k-1];
            assign rad_in       = rad_reg[k-1];
            assign tag_stage_in = tag_reg[k-1];
        end

        always_comb begin
            t     = {rem_in, rad_in[2*RW-1:2*RW-2]};
            trial = {1'b0, root_in, 2'b01};
            diff  = t - trial;
            ge    = (t >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[RW:0] : t[RW:0];
                root_reg[k] <= {root_in[RW-2:0], ge};
                rad_reg[k]  <= {rad_in[2*RW-3:0], 2'b00};
                tag_reg[k]  <= tag_stage_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign tag_out   = tag_reg[RW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/point_segment_distance_core.sv =====
// Throughput: one beat per cycle while the output register is free or being emptied;
// the divider and the square root are fully pipelined, one quotient bit and one root
// bit per stage.
// Reset: synchronous, active low; clears every stage valid bit and loads the tolerance
// register with round(0.001 * 2^FRAC_BITS).
`default_nettype none

module point_segment_distance_core #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [psd_pkg::TOL_WIDTH-1:0]     cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     s_seg_a_x,
    input  wire logic signed [COORD_WIDTH-1:0]     s_seg_a_y,
    input  wire logic signed [COORD_WIDTH-1:0]     s_seg_b_x,
    input  wire logic signed [COORD_WIDTH-1:0]     s_seg_b_y,
    input  wire logic signed [COORD_WIDTH-1:0]     s_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]     s_point_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [COORD_WIDTH:0]                   m_distance,
    output logic signed [COORD_WIDTH-1:0]          m_nearest_x,
    output logic signed [COORD_WIDTH-1:0]          m_nearest_y
);

    import psd_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int QW   = CW + 1;         // magnitude of a coordinate difference
    localparam int PW   = 2 * QW;         // product of two magnitudes
    localparam int L2W  = PW + 1;         // sum of two products, squared length
    localparam int DOTW = PW + 2;         // signed dot product
    localparam int LO   = QW + 1;         // low slice of the dot product multiplier
    localparam int NW   = L2W + QW;       // division numerator
    localparam int RW   = (L2W + 1) / 2;  // square root width
    localparam int DW   = CW + 1;         // distance output width
    localparam int TAGW = 6 * CW + 4;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'((2 ** FRAC_BITS + 500) / 1000);

    // Which point the result is taken from.
    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_MID
    } sel_t;

    // The whole pipeline moves as one whenever the output register is free
    // or is being emptied this cycle, so a stall holds every stage in place.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Tolerance register.
    logic [TOL_WIDTH-1:0] tol_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Stage 1: segment direction D = B - A and offset W = P - A.
    logic                 v1_reg;
    logic signed [CW:0]   dx1_reg, dy1_reg, wx1_reg, wy1_reg;
    logic [CW-1:0]        ax1_reg, ay1_reg, bx1_reg, by1_reg, px1_reg, py1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= {s_seg_b_x[CW-1], s_seg_b_x} - {s_seg_a_x[CW-1], s_seg_a_x};
            dy1_reg <= {s_seg_b_y[CW-1], s_seg_b_y} - {s_seg_a_y[CW-1], s_seg_a_y};
            wx1_reg <= {s_point_x[CW-1], s_point_x} - {s_seg_a_x[CW-1], s_seg_a_x};
            wy1_reg <= {s_point_y[CW-1], s_point_y} - {s_seg_a_y[CW-1], s_seg_a_y};
            ax1_reg <= s_seg_a_x;
            ay1_reg <= s_seg_a_y;
            bx1_reg <= s_seg_b_x;
            by1_reg <= s_seg_b_y;
            px1_reg <= s_point_x;
            py1_reg <= s_point_y;
        end
    end

    // Stage 2: magnitudes and signs, and the zero-length test against the
    // tolerance on both axes.
    logic                 v2_reg;
    logic [QW-1:0]        adx2_reg, ady2_reg, awx2_reg, awy2_reg;
    logic                 n1_2_reg, n2_2_reg, sdx2_reg, sdy2_reg, degen2_reg;
    logic [CW-1:0]        ax2_reg, ay2_reg, bx2_reg, by2_reg, px2_reg, py2_reg;
    logic [QW-1:0]        adx2_next, ady2_next, awx2_next, awy2_next, tol_ext;

    always_comb begin
        adx2_next = dx1_reg[CW] ? -dx1_reg : dx1_reg;
        ady2_next = dy1_reg[CW] ? -dy1_reg : dy1_reg;
        awx2_next = wx1_reg[CW] ? -wx1_reg : wx1_reg;
        awy2_next = wy1_reg[CW] ? -wy1_reg : wy1_reg;
        tol_ext   = {{(QW-TOL_WIDTH){1'b0}}, tol_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adx2_reg   <= adx2_next;
            ady2_reg   <= ady2_next;
            awx2_reg   <= awx2_next;
            awy2_reg   <= awy2_next;
            n1_2_reg   <= wx1_reg[CW] ^ dx1_reg[CW];
            n2_2_reg   <= wy1_reg[CW] ^ dy1_reg[CW];
            sdx2_reg   <= dx1_reg[CW];
            sdy2_reg   <= dy1_reg[CW];
            degen2_reg <= (adx2_next <= tol_ext) && (ady2_next <= tol_ext);
            ax2_reg    <= ax1_reg;
            ay2_reg    <= ay1_reg;
            bx2_reg    <= bx1_reg;
            by2_reg    <= by1_reg;
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;
        end
    end

    // Stage 3: the four magnitude products for the dot product and the
    // squared length.
    logic                 v3_reg;
    logic [PW-1:0]        p1_3_reg, p2_3_reg, sqx3_reg, sqy3_reg;
    logic                 n1_3_reg, n2_3_reg, sdx3_reg, sdy3_reg, degen3_reg;
    logic [QW-1:0]        adx3_reg, ady3_reg;
    logic [CW-1:0]        ax3_reg, ay3_reg, bx3_reg, by3_reg, px3_reg, py3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_3_reg   <= awx2_reg * adx2_reg;
            p2_3_reg   <= awy2_reg * ady2_reg;
            sqx3_reg   <= adx2_reg * adx2_reg;
            sqy3_reg   <= ady2_reg * ady2_reg;
            n1_3_reg   <= n1_2_reg;
            n2_3_reg   <= n2_2_reg;
            sdx3_reg   <= sdx2_reg;
            sdy3_reg   <= sdy2_reg;
            degen3_reg <= degen2_reg;
            adx3_reg   <= adx2_reg;
            ady3_reg   <= ady2_reg;
            ax3_reg    <= ax2_reg;
            ay3_reg    <= ay2_reg;
            bx3_reg    <= bx2_reg;
            by3_reg    <= by2_reg;
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
        end
    end

    // Stage 4: signed dot product W.D and squared length D.D.
    logic                   v4_reg;
    logic signed [DOTW-1:0] dot4_reg;
    logic [L2W-1:0]         len2_4_reg;
    logic                   sdx4_reg, sdy4_reg, degen4_reg;
    logic [QW-1:0]          adx4_reg, ady4_reg;
    logic [CW-1:0]          ax4_reg, ay4_reg, bx4_reg, by4_reg, px4_reg, py4_reg;
    logic signed [DOTW-1:0] t1, t2;

    always_comb begin
        t1 = $signed({2'b00, p1_3_reg});
        t2 = $signed({2'b00, p2_3_reg});
        if (n1_3_reg) begin
            t1 = -t1;
        end
        if (n2_3_reg) begin
            t2 = -t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot4_reg   <= t1 + t2;
            len2_4_reg <= {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
            sdx4_reg   <= sdx3_reg;
            sdy4_reg   <= sdy3_reg;
            degen4_reg <= degen3_reg;
            adx4_reg   <= adx3_reg;
            ady4_reg   <= ady3_reg;
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            bx4_reg    <= bx3_reg;
            by4_reg    <= by3_reg;
            px4_reg    <= px3_reg;
            py4_reg    <= py3_reg;
        end
    end

    // Stage 5: pick the end. A degenerate segment takes A. A negative dot product
    // puts the foot before A, one above the squared length puts it past B;
    // equality lands exactly on an end through the division.
    logic                 v5_reg;
    sel_t                 sel5_reg;
    sel_t                 sel5_next;
    logic [L2W-1:0]       dm5_reg, len2_5_reg;
    logic                 sdx5_reg, sdy5_reg;
    logic [QW-1:0]        adx5_reg, ady5_reg;
    logic [CW-1:0]        ax5_reg, ay5_reg, bx5_reg, by5_reg, px5_reg, py5_reg;

    always_comb begin
        if (degen4_reg || dot4_reg[DOTW-1]) begin
            sel5_next = SEL_A;
        end else if (dot4_reg[L2W-1:0] > len2_4_reg) begin
            sel5_next = SEL_B;
        end else begin
            sel5_next = SEL_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel5_reg   <= sel5_next;
            dm5_reg    <= dot4_reg[L2W-1:0];
            len2_5_reg <= len2_4_reg;
            sdx5_reg   <= sdx4_reg;
            sdy5_reg   <= sdy4_reg;
            adx5_reg   <= adx4_reg;
            ady5_reg   <= ady4_reg;
            ax5_reg    <= ax4_reg;
            ay5_reg    <= ay4_reg;
            bx5_reg    <= bx4_reg;
            by5_reg    <= by4_reg;
            px5_reg    <= px4_reg;
            py5_reg    <= py4_reg;
        end
    end

    // Stage 6: dot * |D| per axis, as two partial products each.
    logic                   v6_reg;
    logic [LO+QW-1:0]       ppxl6_reg, ppyl6_reg;
    logic [PW-1:0]          ppxh6_reg, ppyh6_reg;
    logic [L2W-1:0]         len2_6_reg;
    logic [TAGW-1:0]        tag6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ppxl6_reg  <= dm5_reg[LO-1:0] * adx5_reg;
            ppyl6_reg  <= dm5_reg[LO-1:0] * ady5_reg;
            ppxh6_reg  <= dm5_reg[L2W-1:LO] * adx5_reg;
            ppyh6_reg  <= dm5_reg[L2W-1:LO] * ady5_reg;
            len2_6_reg <= len2_5_reg;
            tag6_reg   <= {sel5_reg, sdx5_reg, sdy5_reg, ax5_reg, ay5_reg,
                           bx5_reg, by5_reg, px5_reg, py5_reg};
        end
    end

    // Stage 7: combine the partial products into the numerators.
    logic                 v7_reg;
    logic [NW-1:0]        numx7_reg, numy7_reg;
    logic [L2W-1:0]       len2_7_reg;
    logic [TAGW-1:0]      tag7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numx7_reg  <= {ppxh6_reg, {LO{1'b0}}} + {{(NW-LO-QW){1'b0}}, ppxl6_reg};
            numy7_reg  <= {ppyh6_reg, {LO{1'b0}}} + {{(NW-LO-QW){1'b0}}, ppyl6_reg};
            len2_7_reg <= len2_6_reg;
            tag7_reg   <= tag6_reg;
        end
    end

    // Offsets along the segment: dot * |D| / len2 on each axis.
    logic             dv;
    logic [QW-1:0]    qx, qy;
    logic [TAGW-1:0]  dtag;

    psd_div2 #(
        .QW   (QW),
        .DENW (L2W),
        .TW   (TAGW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .num_x     (numx7_reg),
        .num_y     (numy7_reg),
        .den       (len2_7_reg),
        .tag_in    (tag7_reg),
        .out_valid (dv),
        .quo_x     (qx),
        .quo_y     (qy),
        .tag_out   (dtag)
    );

    sel_t           d_sel;
    logic           d_sdx, d_sdy;
    logic [CW-1:0]  d_ax, d_ay, d_bx, d_by, d_px, d_py;

    assign d_sel = sel_t'(dtag[6*CW+3:6*CW+2]);
    assign d_sdx = dtag[6*CW+1];
    assign d_sdy = dtag[6*CW];
    assign d_ax  = dtag[6*CW-1:5*CW];
    assign d_ay  = dtag[5*CW-1:4*CW];
    assign d_bx  = dtag[4*CW-1:3*CW];
    assign d_by  = dtag[3*CW-1:2*CW];
    assign d_px  = dtag[2*CW-1:CW];
    assign d_py  = dtag[CW-1:0];

    // Stage A: nearest point. A foot inside the segment always lies between
    // A and B, so the sum fits the coordinate word.
    logic             va_reg;
    logic [CW-1:0]    nxa_reg, nya_reg, pxa_reg, pya_reg;
    logic [CW-1:0]    nxa_next, nya_next;
    logic [CW+1:0]    ofsx, ofsy, midx, midy;

    always_comb begin
        ofsx = d_sdx ? -{1'b0, qx} : {1'b0, qx};
        ofsy = d_sdy ? -{1'b0, qy} : {1'b0, qy};
        midx = {{2{d_ax[CW-1]}}, d_ax} + ofsx;
        midy = {{2{d_ay[CW-1]}}, d_ay} + ofsy;
        case (d_sel)
            SEL_B: begin
                nxa_next = d_bx;
                nya_next = d_by;
            end
            SEL_MID: begin
                nxa_next = midx[CW-1:0];
                nya_next = midy[CW-1:0];
            end
            default: begin
                nxa_next = d_ax;
                nya_next = d_ay;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nxa_reg <= nxa_next;
            nya_reg <= nya_next;
            pxa_reg <= d_px;
            pya_reg <= d_py;
        end
    end

    // Stage B: error vector magnitudes.
    logic             vb_reg;
    logic [QW-1:0]    aexb_reg, aeyb_reg;
    logic [CW-1:0]    nxb_reg, nyb_reg;
    logic [CW:0]      exb, eyb;

    always_comb begin
        exb = {pxa_reg[CW-1], pxa_reg} - {nxa_reg[CW-1], nxa_reg};
        eyb = {pya_reg[CW-1], pya_reg} - {nya_reg[CW-1], nya_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            aexb_reg <= exb[CW] ? -exb : exb;
            aeyb_reg <= eyb[CW] ? -eyb : eyb;
            nxb_reg  <= nxa_reg;
            nyb_reg  <= nya_reg;
        end
    end

    // Stage C: squares of the error components.
    logic             vc_reg;
    logic [PW-1:0]    sqexc_reg, sqeyc_reg;
    logic [CW-1:0]    nxc_reg, nyc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqexc_reg <= aexb_reg * aexb_reg;
            sqeyc_reg <= aeyb_reg * aeyb_reg;
            nxc_reg   <= nxb_reg;
            nyc_reg   <= nyb_reg;
        end
    end

    // Stage D: squared distance.
    logic             vd_reg;
    logic [L2W-1:0]   ssumd_reg;
    logic [CW-1:0]    nxd_reg, nyd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ssumd_reg <= {1'b0, sqexc_reg} + {1'b0, sqeyc_reg};
            nxd_reg   <= nxc_reg;
            nyd_reg   <= nyc_reg;
        end
    end

    logic             sv;
    logic [RW-1:0]    root;
    logic [2*CW-1:0]  stag;

    psd_isqrt #(
        .SW (L2W),
        .RW (RW),
        .TW (2 * CW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vd_reg),
        .radicand  (ssumd_reg),
        .tag_in    ({nxd_reg, nyd_reg}),
        .out_valid (sv),
        .root      (root),
        .tag_out   (stag)
    );

    // Output register. The distance saturates to all ones should the root
    // outgrow its field, which the default widths never reach.
    logic             m_valid_reg;
    logic [DW-1:0]    m_distance_reg;
    logic [CW-1:0]    m_nearest_x_reg, m_nearest_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_distance_reg  <= (root[RW-1:DW] != '0) ? {DW{1'b1}} : root[DW-1:0];
            m_nearest_x_reg <= stag[2*CW-1:CW];
            m_nearest_y_reg <= stag[CW-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = m_distance_reg;
    assign m_nearest_x = m_nearest_x_reg;
    assign m_nearest_y = m_nearest_y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/psd_checker.sv =====
`default_nettype none

module psd_checker #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [COORD_WIDTH:0]           m_distance,
    input wire logic [COORD_WIDTH-1:0]         m_nearest_x,
    input wire logic [COORD_WIDTH-1:0]         m_nearest_y
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    // The pipeline never holds the input back while the output is taken.
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result beat is taken");

    // An empty output register always leaves room for a new beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance)
            && $stable(m_nearest_x) && $stable(m_nearest_y))
        else $error("stalled result beat changed");

endmodule

bind point_segment_distance_core psd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psd_checker (.*);

`default_nettype wire

// ===== tb/tb_point_segment_distance_core.sv =====
`default_nettype none

// Scoreboard for the distance core. The prediction is exact integer arithmetic
// at widths wide enough that nothing can overflow.
class psd_scoreboard;
    typedef struct {
        logic [32:0]        distance;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } nearest_t;

    nearest_t   pending_q[$];
    logic [15:0] tol;
    int          errors;

    function new();
        tol    = 16'd66;
        errors = 0;
    endfunction

    // Integer square root, rounded down, by one root bit per step.
    static function logic [64:0] isqrt(logic [129:0] v);
        logic [64:0]  r;
        logic [64:0]  c;
        r = '0;
        for (int i = 64; i >= 0; i--) begin
            c = r | (65'd1 << i);
            if ({65'd0, c} * {65'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    // Signed quotient truncated toward zero; the divisor is always positive here.
    static function logic signed [63:0] scaled_offset(logic signed [129:0] dot,
                                                     logic signed [33:0] d,
                                                     logic signed [129:0] len2);
        logic signed [129:0] num;
        num = dot * d;
        return 64'(num / len2);
    endfunction

    function void note_input(logic signed [31:0] ax, logic signed [31:0] ay,
                             logic signed [31:0] bx, logic signed [31:0] by,
                             logic signed [31:0] px, logic signed [31:0] py);
        logic signed [33:0]  dx, dy, ex, ey;
        logic signed [129:0] dot, len2, sum;
        logic signed [63:0]  nx, ny;
        logic [64:0]         root;
        nearest_t            e;
        dx = 34'(bx) - 34'(ax);
        dy = 34'(by) - 34'(ay);
        nx = 64'(ax);
        ny = 64'(ay);
        if (!((dx < 0 ? -dx : dx) <= tol && (dy < 0 ? -dy : dy) <= tol)) begin
            dot  = 130'(34'(px) - 34'(ax)) * 130'(dx) + 130'(34'(py) - 34'(ay)) * 130'(dy);
            len2 = 130'(dx) * 130'(dx) + 130'(dy) * 130'(dy);
            if (dot < 0) begin
                nx = 64'(ax);
                ny = 64'(ay);
            end else if (dot > len2) begin
                nx = 64'(bx);
                ny = 64'(by);
            end else begin
                nx = 64'(ax) + scaled_offset(dot, dx, len2);
                ny = 64'(ay) + scaled_offset(dot, dy, len2);
            end
        end
        ex   = 34'(64'(px) - nx);
        ey   = 34'(64'(py) - ny);
        sum  = 130'(ex) * 130'(ex) + 130'(ey) * 130'(ey);
        root = isqrt(sum);
        e.distance = (root > 65'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : root[32:0];
        e.nx       = nx[31:0];
        e.ny       = ny[31:0];
        pending_q.push_back(e);
    endfunction

    function void check_result(logic [32:0] distance, logic signed [31:0] nx,
                               logic signed [31:0] ny);
        nearest_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: result beat with nothing expected (distance %h x %h y %h)",
                     $time, distance, nx, ny);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (distance !== e.distance) begin
            $display("%0t: distance expected %h actual %h", $time, e.distance, distance);
            errors++;
        end
        if (nx !== e.nx) begin
            $display("%0t: nearest_x expected %h actual %h", $time, e.nx, nx);
            errors++;
        end
        if (ny !== e.ny) begin
            $display("%0t: nearest_y expected %h actual %h", $time, e.ny, ny);
            errors++;
        end
    endfunction
endclass

module tb_point_segment_distance_core;
    localparam int LATENCY     = 79;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_seg_a_x, s_seg_a_y, s_seg_b_x, s_seg_b_y, s_point_x, s_point_y;
    logic               m_valid;
    logic               m_ready;
    logic [32:0]        m_distance;
    logic signed [31:0] m_nearest_x, m_nearest_y;

    psd_scoreboard      sb;
    int                 cycles;
    // The receiver idles only while this is set, which leaves a long calm stretch.
    bit                 sink_stalls;

    point_segment_distance_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_seg_a_x   (s_seg_a_x),
        .s_seg_a_y   (s_seg_a_y),
        .s_seg_b_x   (s_seg_b_x),
        .s_seg_b_y   (s_seg_b_y),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_nearest_x (m_nearest_x),
        .m_nearest_y (m_nearest_y)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_seg_a_x   = '0;
        s_seg_a_y   = '0;
        s_seg_b_x   = '0;
        s_seg_b_y   = '0;
        s_point_x   = '0;
        s_point_y   = '0;
        m_ready     = 1'b0;
        sink_stalls = 1'b1;
        cycles      = 0;
    end

    // Result side: check every beat taken, then decide the next cycle's ready.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** point_segment_distance_core: FAILED **");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_distance, m_nearest_x, m_nearest_y);
            m_ready <= !(sink_stalls && $urandom_range(99) < 14);
        end
    end

    // Sends one input beat, optionally after a random idle gap, and records it on acceptance.
    task automatic send_beat(input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] bx, input logic [31:0] by,
                             input logic [31:0] px, input logic [31:0] py,
                             input bit may_idle);
        while (may_idle && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_seg_a_x <= ax;
        s_seg_a_y <= ay;
        s_seg_b_x <= bx;
        s_seg_b_y <= by;
        s_point_x <= px;
        s_point_y <= py;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(ax, ay, bx, by, px, py);
    endtask

    // Waits for the pipeline to drain, then writes the tolerance register.
    task automatic set_tolerance(input logic [15:0] value);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.tol = value;
    endtask

    // Coordinates are mostly small or moderate so that projections land inside
    // the segment often; some use the full range to exercise the wide products.
    function automatic logic [31:0] rand_coord(int bias);
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3:    return 32'($signed(bias) + $signed(32'($urandom_range(400)) - 200));
            default: return 32'($signed(bias) + $signed($urandom() >>> 12) - 32'sh0008_0000);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int          base;
        logic [31:0] ax, ay;
        bit          idle;
        for (int i = 0; i < count; i++) begin
            base = $signed($urandom()) >>> ($urandom_range(1) ? 4 : 20);
            // Long stretch in the middle of each phase with no idling at all.
            idle        = !(i > count / 3 && i < count / 2);
            sink_stalls = idle;
            ax = rand_coord(base);
            ay = rand_coord(base);
            if ($urandom_range(9) == 0)
                // Nearly degenerate segment around the tolerance.
                send_beat(ax, ay, ax + 32'($urandom_range(140)) - 70,
                          ay + 32'($urandom_range(140)) - 70,
                          rand_coord(base), rand_coord(base), idle);
            else
                send_beat(ax, ay, rand_coord(base), rand_coord(base),
                          rand_coord(base), rand_coord(base), idle);
        end
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at the reset tolerance.
        // Degenerate segment, exactly equal endpoints and just within the tolerance.
        send_beat(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                  32'h0004_0000, 32'h0006_0000, 1'b0);
        send_beat(32'h0001_0000, 32'h0002_0000, 32'h0001_0042, 32'hFFFF_FFBE + 32'h0002_0000,
                  32'h0000_0000, 32'h0000_0000, 1'b0);
        // Just outside the tolerance on one axis.
        send_beat(32'h0, 32'h0, 32'h0000_0043, 32'h0, 32'h0000_0020, 32'h0001_0000, 1'b0);
        // Foot behind A, beyond B, at A exactly, at B exactly, and in the middle.
        send_beat(32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'hFFFB_0000, 32'h0003_0000, 1'b0);
        send_beat(32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h000F_0000, 32'hFFFD_0000, 1'b0);
        send_beat(32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0, 32'h0005_0000, 1'b0);
        send_beat(32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h000A_0000, 32'h0005_0000, 1'b0);
        send_beat(32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 32'h0003_0000,
                  32'h0002_0000, 32'h0004_0000, 1'b0);
        // Negative direction where truncation toward zero matters.
        send_beat(32'h0, 32'h0, 32'hFFFF_FFFD, 32'hFFFF_FFF9, 32'hFFFF_FFFF,
                  32'h0000_0001, 1'b0);
        send_beat(32'h0, 32'h0, 32'h0007_0003, 32'hFFFD_0001, 32'h0001_2345,
                  32'h0009_8765, 1'b0);
        // Full-range extremes.
        send_beat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 1'b0);
        send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h0, 32'hFFFF_FFFF, 1'b0);
        random_phase(500);

        // Zero tolerance: only identical endpoints are degenerate.
        set_tolerance(16'd0);
        send_beat(32'h0, 32'h0, 32'h1, 32'h0, 32'h0000_0001, 32'h0001_0000, 1'b0);
        send_beat(32'h5, 32'h5, 32'h5, 32'h5, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        random_phase(400);

        // Largest tolerance: many segments become degenerate.
        set_tolerance(16'hFFFF);
        send_beat(32'h0, 32'h0, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0003_0000, 32'h0, 1'b0);
        send_beat(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0);
        random_phase(300);

        set_tolerance(16'h1234);
        random_phase(300);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("** point_segment_distance_core: PASSED **");
        else
            $display("** point_segment_distance_core: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

// ===== point_segment_distance_core.f =====
hw/rtl/psd_pkg.sv
hw/rtl/psd_div2.sv
hw/rtl/psd_isqrt.sv
hw/rtl/point_segment_distance_core.sv
hw/rtl/psd_checker.sv
tb/tb_point_segment_distance_core.sv
